[design/qge_pkg.sv]
`timescale 1ns / 1ps

package qge_pkg;

    // field widths
    localparam int DATA_W       = 32;
    localparam int DT_W         = 25;
    localparam int DRAW_W       = 16;
    localparam int TAG_W        = 16;
    localparam int PROD_W       = 64;
    localparam int WIDE_W       = 65;

    // fixed point
    localparam int FRAC_BITS_DEF = 24;
    localparam int DRAW_FRAC     = 12;

    // register file
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MEAN_REVERSION   = 3'd0,
        REG_VOL_SCALE        = 3'd1,
        REG_SKEW_SLOPE       = 3'd2,
        REG_VOL_OFFSET       = 3'd3,
        REG_STEP_LENGTH      = 3'd4,
        REG_ROOT_STEP_LENGTH = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] mean_reversion;
        logic signed [DATA_W-1:0] vol_scale;
        logic signed [DATA_W-1:0] skew_slope;
        logic signed [DATA_W-1:0] vol_offset;
        logic [DT_W-1:0]          step_length;
        logic [DT_W-1:0]          root_step_length;
    } qge_cfg_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     clip;
    } sat_t;

    localparam logic signed [WIDE_W-1:0] SAT_MAX = 65'sd2147483647;
    localparam logic signed [WIDE_W-1:0] SAT_MIN = -65'sd2147483648;

    // clip a wide signed value to the 32-bit range
    function automatic sat_t sat_value(input logic signed [WIDE_W-1:0] v);
        sat_t r;
        if (v > SAT_MAX)
        begin
            r.value = SAT_MAX[DATA_W-1:0];
            r.clip  = 1'b1;
        end
        else if (v < SAT_MIN)
        begin
            r.value = SAT_MIN[DATA_W-1:0];
            r.clip  = 1'b1;
        end
        else
        begin
            r.value = v[DATA_W-1:0];
            r.clip  = 1'b0;
        end
        return r;
    endfunction

    // add half, floor shift, clip
    function automatic sat_t round_sat(input logic signed [PROD_W-1:0] p,
                                       input int unsigned s);
        logic signed [WIDE_W-1:0] sum;
        logic signed [WIDE_W-1:0] one;
        one = WIDE_W'(1);
        sum = WIDE_W'(p) + (one <<< (s - 1));
        return sat_value(sum >>> s);
    endfunction

endpackage

[design/qge_step_if.sv]
`timescale 1ns / 1ps

interface qge_step_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [qge_pkg::DATA_W-1:0]     factor_x;
    logic signed [qge_pkg::DATA_W-1:0]     factor_y;
    logic signed [qge_pkg::DRAW_W-1:0]     normal_draw;
    logic [qge_pkg::TAG_W-1:0]             path_tag;

    modport source (output valid, factor_x, factor_y, normal_draw, path_tag, input ready);
    modport sink   (input valid, factor_x, factor_y, normal_draw, path_tag, output ready);
endinterface

[design/qge_result_if.sv]
`timescale 1ns / 1ps

interface qge_result_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [qge_pkg::DATA_W-1:0]     next_x;
    logic signed [qge_pkg::DATA_W-1:0]     next_y;
    logic                                  saturated;
    logic [qge_pkg::TAG_W-1:0]             tag_out;

    modport source (output valid, next_x, next_y, saturated, tag_out, input ready);
    modport sink   (input valid, next_x, next_y, saturated, tag_out, output ready);
endinterface

[design/qge_regs.sv]
`timescale 1ns / 1ps

module qge_regs
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [qge_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [qge_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [qge_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                pready,
    output qge_pkg::qge_cfg_t                   cfg
);

    qge_pkg::qge_cfg_t cfg_reg;
    qge_pkg::reg_idx_t idx;
    logic              wr_en;

    assign pready = 1'b1;
    assign idx    = qge_pkg::reg_idx_t'(paddr[qge_pkg::CFG_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // register writes, unknown index ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            case (idx)
                qge_pkg::REG_MEAN_REVERSION:   cfg_reg.mean_reversion   <= pwdata;
                qge_pkg::REG_VOL_SCALE:        cfg_reg.vol_scale        <= pwdata;
                qge_pkg::REG_SKEW_SLOPE:       cfg_reg.skew_slope       <= pwdata;
                qge_pkg::REG_VOL_OFFSET:       cfg_reg.vol_offset       <= pwdata;
                qge_pkg::REG_STEP_LENGTH:
                    cfg_reg.step_length      <= pwdata[qge_pkg::DT_W-1:0];
                qge_pkg::REG_ROOT_STEP_LENGTH:
                    cfg_reg.root_step_length <= pwdata[qge_pkg::DT_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        case (idx)
            qge_pkg::REG_MEAN_REVERSION:   prdata = cfg_reg.mean_reversion;
            qge_pkg::REG_VOL_SCALE:        prdata = cfg_reg.vol_scale;
            qge_pkg::REG_SKEW_SLOPE:       prdata = cfg_reg.skew_slope;
            qge_pkg::REG_VOL_OFFSET:       prdata = cfg_reg.vol_offset;
            qge_pkg::REG_STEP_LENGTH:
                prdata = qge_pkg::CFG_DATA_W'(cfg_reg.step_length);
            qge_pkg::REG_ROOT_STEP_LENGTH:
                prdata = qge_pkg::CFG_DATA_W'(cfg_reg.root_step_length);
            default:                       prdata = '0;
        endcase
    end

endmodule

[design/qge_datapath.sv]
`timescale 1ns / 1ps

module qge_datapath #(
    parameter int FRAC_BITS = qge_pkg::FRAC_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  qge_pkg::qge_cfg_t    cfg,
    qge_step_if.sink             step,
    qge_result_if.source         result
);

    localparam int NSTG = 8;
    localparam int DW   = qge_pkg::DATA_W;
    localparam int PW   = qge_pkg::PROD_W;
    localparam int WW   = qge_pkg::WIDE_W;

    logic [NSTG-1:0] vld_reg;
    logic            adv;

    // operands carried down the pipe
    logic signed [DW-1:0]                 x_reg   [NSTG-1];
    logic signed [DW-1:0]                 y_reg   [NSTG-1];
    logic signed [qge_pkg::DRAW_W-1:0]    z_reg   [NSTG-2];
    logic [qge_pkg::TAG_W-1:0]            tag_reg [NSTG];

    // stage 1: products of x and y
    logic signed [PW-1:0] p_bx_reg, p_kx_reg, p_ky_reg;
    // stage 2
    logic signed [DW-1:0] inner_reg, bx_reg, ky2_reg;
    logic                 flag2_reg;
    // stage 3
    logic signed [PW-1:0] p_sig_reg, p_dx_reg;
    logic signed [DW-1:0] ky3_reg;
    logic                 flag3_reg;
    // stage 4
    logic signed [DW-1:0] sig_r_reg, dx4_reg, ky4_reg;
    logic                 flag4_reg;
    // stage 5
    logic signed [PW-1:0] p_vs_reg, p_sq_reg;
    logic signed [DW-1:0] dx5_reg, ky5_reg;
    logic                 flag5_reg;
    // stage 6
    logic signed [DW-1:0] vs_reg, by_reg, dx6_reg;
    logic                 flag6_reg;
    // stage 7
    logic signed [PW-1:0] p_dz_reg, p_dy_reg;
    logic signed [DW-1:0] dx7_reg;
    logic                 flag7_reg;
    // stage 8, output register
    logic signed [DW-1:0] nx_reg, ny_reg;
    logic                 flag8_reg;

    // combinational next values
    qge_pkg::sat_t        r_bx, r_kx, r_ky, s_inner, s_bx;
    qge_pkg::sat_t        r_sig, r_dx, r_vs, r_sq, s_by, r_dz, r_dy, s_nx, s_ny;
    logic signed [DW:0]   inner_sum, bx_diff;
    logic signed [DW+1:0] by_diff, nx_sum;
    logic signed [DW:0]   ny_sum;
    logic signed [DW-1:0] inner_next, bx_next, ky_next, sig_r_next, dx_next;
    logic signed [DW-1:0] vs_next, by_next, nx_next, ny_next;
    logic                 flag2_next, flag4_next, flag6_next, flag8_next;

    // whole pipe moves unless the output holds an untaken result
    assign adv        = !vld_reg[NSTG-1] || result.ready;
    assign step.ready = adv;

    // stage 2: local vol inner term and x drift
    always_comb
    begin
        r_bx       = qge_pkg::round_sat(p_bx_reg, FRAC_BITS);
        inner_sum  = (DW+1)'(r_bx.value) + (DW+1)'(cfg.vol_offset);
        s_inner    = qge_pkg::sat_value(WW'(inner_sum));
        r_kx       = qge_pkg::round_sat(p_kx_reg, FRAC_BITS);
        bx_diff    = (DW+1)'(y_reg[0]) - (DW+1)'(r_kx.value);
        s_bx       = qge_pkg::sat_value(WW'(bx_diff));
        r_ky       = qge_pkg::round_sat(p_ky_reg, FRAC_BITS);
        inner_next = s_inner.value;
        bx_next    = s_bx.value;
        ky_next    = r_ky.value;
        flag2_next = r_bx.clip | s_inner.clip | r_kx.clip | s_bx.clip | r_ky.clip;
    end

    // stage 4: sigR and x drift increment
    always_comb
    begin
        r_sig      = qge_pkg::round_sat(p_sig_reg, FRAC_BITS);
        r_dx       = qge_pkg::round_sat(p_dx_reg, FRAC_BITS);
        sig_r_next = r_sig.value;
        dx_next    = r_dx.value;
        flag4_next = flag3_reg | r_sig.clip | r_dx.clip;
    end

    // stage 6: scaled vol and y drift
    always_comb
    begin
        r_vs       = qge_pkg::round_sat(p_vs_reg, FRAC_BITS);
        r_sq       = qge_pkg::round_sat(p_sq_reg, FRAC_BITS);
        by_diff    = (DW+2)'(r_sq.value) - ((DW+2)'(ky5_reg) <<< 1);
        s_by       = qge_pkg::sat_value(WW'(by_diff));
        vs_next    = r_vs.value;
        by_next    = s_by.value;
        flag6_next = flag5_reg | r_vs.clip | r_sq.clip | s_by.clip;
    end

    // stage 8: final sums
    always_comb
    begin
        r_dz       = qge_pkg::round_sat(p_dz_reg, qge_pkg::DRAW_FRAC);
        r_dy       = qge_pkg::round_sat(p_dy_reg, FRAC_BITS);
        nx_sum     = (DW+2)'(x_reg[NSTG-2]) + (DW+2)'(dx7_reg) + (DW+2)'(r_dz.value);
        ny_sum     = (DW+1)'(y_reg[NSTG-2]) + (DW+1)'(r_dy.value);
        s_nx       = qge_pkg::sat_value(WW'(nx_sum));
        s_ny       = qge_pkg::sat_value(WW'(ny_sum));
        nx_next    = s_nx.value;
        ny_next    = s_ny.value;
        flag8_next = flag7_reg | r_dz.clip | r_dy.clip | s_nx.clip | s_ny.clip;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NSTG-2:0], step.valid};
        end
    end

    // carried operands
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg[0]   <= step.factor_x;
            y_reg[0]   <= step.factor_y;
            z_reg[0]   <= step.normal_draw;
            tag_reg[0] <= step.path_tag;
            for (int i = 1; i < NSTG - 1; i++)
            begin
                x_reg[i] <= x_reg[i-1];
                y_reg[i] <= y_reg[i-1];
            end
            for (int i = 1; i < NSTG - 2; i++)
            begin
                z_reg[i] <= z_reg[i-1];
            end
            for (int i = 1; i < NSTG; i++)
            begin
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    // arithmetic stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // stage 1
            p_bx_reg  <= PW'(cfg.skew_slope) * PW'(step.factor_x);
            p_kx_reg  <= PW'(cfg.mean_reversion) * PW'(step.factor_x);
            p_ky_reg  <= PW'(cfg.mean_reversion) * PW'(step.factor_y);
            // stage 2
            inner_reg <= inner_next;
            bx_reg    <= bx_next;
            ky2_reg   <= ky_next;
            flag2_reg <= flag2_next;
            // stage 3
            p_sig_reg <= PW'(cfg.vol_scale) * PW'(inner_reg);
            p_dx_reg  <= PW'(bx_reg) * PW'($signed({1'b0, cfg.step_length}));
            ky3_reg   <= ky2_reg;
            flag3_reg <= flag2_reg;
            // stage 4
            sig_r_reg <= sig_r_next;
            dx4_reg   <= dx_next;
            ky4_reg   <= ky3_reg;
            flag4_reg <= flag4_next;
            // stage 5
            p_vs_reg  <= PW'(sig_r_reg) * PW'($signed({1'b0, cfg.root_step_length}));
            p_sq_reg  <= PW'(sig_r_reg) * PW'(sig_r_reg);
            dx5_reg   <= dx4_reg;
            ky5_reg   <= ky4_reg;
            flag5_reg <= flag4_reg;
            // stage 6
            vs_reg    <= vs_next;
            by_reg    <= by_next;
            dx6_reg   <= dx5_reg;
            flag6_reg <= flag6_next;
            // stage 7
            p_dz_reg  <= PW'(vs_reg) * PW'(z_reg[NSTG-3]);
            p_dy_reg  <= PW'(by_reg) * PW'($signed({1'b0, cfg.step_length}));
            dx7_reg   <= dx6_reg;
            flag7_reg <= flag6_reg;
            // stage 8
            nx_reg    <= nx_next;
            ny_reg    <= ny_next;
            flag8_reg <= flag8_next;
        end
    end

    // result port
    assign result.valid     = vld_reg[NSTG-1];
    assign result.next_x    = nx_reg;
    assign result.next_y    = ny_reg;
    assign result.saturated = flag8_reg;
    assign result.tag_out   = tag_reg[NSTG-1];

`ifndef SYNTH
    // a held stall freezes every valid bit
    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during a stall");

    // an accepted request lands in the first stage
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        step.valid && step.ready |=> vld_reg[0])
        else $error("accepted request missing from first stage");

    // an untaken result blocks new requests
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |-> !step.ready)
        else $error("request taken while result is held");

    // last internal stage moves into the output register
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NSTG-2] && adv |=> result.valid)
        else $error("result lost on way to output register");
`endif

endmodule

[design/quasi_gaussian_euler_step.sv]
`timescale 1ns / 1ps
// channel   dir   handshake        payload
// step      in    valid / ready    factor_x, factor_y, normal_draw, path_tag
// result    out   valid / ready    next_x, next_y, saturated, tag_out
// apb       in    psel / penable   paddr, pwdata, prdata (pready tied high)
//
// one request accepted per cycle unless an untaken result stalls the pipe
// 8 register stages: four multiply stages, each followed by round/clip
// asynchronous active-low reset clears valid bits and configuration registers
// a result not taken stalls the whole pipe; nothing is dropped or repeated

module quasi_gaussian_euler_step #(
    parameter int FRAC_BITS = qge_pkg::FRAC_BITS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    qge_step_if.sink                            step,
    qge_result_if.source                        result,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [qge_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [qge_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [qge_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                pready
);

    qge_pkg::qge_cfg_t cfg;

    // configuration registers
    qge_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // euler step pipeline
    qge_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .step   (step),
        .result (result)
    );

endmodule

[tb/sv/tb_quasi_gaussian_euler_step.sv]
`timescale 1ns / 1ps

module tb_quasi_gaussian_euler_step;

    localparam int DATA_W         = qge_pkg::DATA_W;
    localparam int DT_W           = qge_pkg::DT_W;
    localparam int DRAW_W         = qge_pkg::DRAW_W;
    localparam int TAG_W          = qge_pkg::TAG_W;
    localparam int DRAW_FRAC      = qge_pkg::DRAW_FRAC;
    localparam int CFG_ADDR_W     = qge_pkg::CFG_ADDR_W;
    localparam int CFG_DATA_W     = qge_pkg::CFG_DATA_W;

    typedef qge_pkg::qge_cfg_t qge_cfg_t;
    typedef qge_pkg::reg_idx_t reg_idx_t;

    localparam int FRAC           = qge_pkg::FRAC_BITS_DEF;
    localparam int NUM_REGS       = 6;
    localparam int PIPE_LAT       = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 80;
    localparam int MAX_GAP        = 13;
    localparam int MAX_REPORTS    = 10;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 200;

    localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh0100_0000;
    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
    localparam logic [DT_W-1:0]          DT_MAX = 25'h1ff_ffff;
    localparam longint                   SAT_HI = 64'sd2147483647;
    localparam longint                   SAT_LO = -64'sd2147483648;

    typedef struct packed {
        logic signed [DATA_W-1:0] next_x;
        logic signed [DATA_W-1:0] next_y;
        logic                     saturated;
        logic [TAG_W-1:0]         tag_out;
    } euler_out_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    qge_step_if   step_ch();
    qge_result_if result_ch();

    qge_cfg_t   shadow_cfg;
    euler_out_t predicted_steps[$];

    int tx_gap_max;
    int rx_gap_max;
    int hold_len;
    int mismatch_cnt;
    int n_requests;
    int n_results;
    int n_clipped;
    int n_settings;
    int n_input_stalls;
    int quiet_cycles;

    quasi_gaussian_euler_step #(
        .FRAC_BITS (FRAC)
    )
    u_dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // clip to the 32-bit signed range, remembering any clip
    function automatic longint clip32(input longint v, inout bit clipped);
        if (v > SAT_HI)
        begin
            clipped = 1'b1;
            return SAT_HI;
        end
        if (v < SAT_LO)
        begin
            clipped = 1'b1;
            return SAT_LO;
        end
        return v;
    endfunction

    // exact product, add half, floor shift, clip
    function automatic longint fixed_mul(input longint a, input longint b, input int shift,
                                         inout bit clipped);
        longint prod;
        prod = a * b + (longint'(1) <<< (shift - 1));
        return clip32(prod >>> shift, clipped);
    endfunction

    // one euler step of the quasi-gaussian factor state
    function automatic euler_out_t predict_euler_step(input qge_cfg_t c,
                                                      input logic signed [DATA_W-1:0] x,
                                                      input logic signed [DATA_W-1:0] y,
                                                      input logic signed [DRAW_W-1:0] z,
                                                      input logic [TAG_W-1:0] tag);
        longint kap;
        longint sig;
        longint bet;
        longint s0;
        longint dt;
        longint sdt;
        longint lx;
        longint ly;
        longint lz;
        longint bs;
        longint inner;
        longint sig_r;
        longint kx;
        longint bx;
        longint dx;
        longint vs;
        longint dz;
        longint sq;
        longint ky;
        longint by;
        longint dy;
        bit clipped;
        euler_out_t r;
        kap = longint'($signed(c.mean_reversion));
        sig = longint'($signed(c.vol_scale));
        bet = longint'($signed(c.skew_slope));
        s0  = longint'($signed(c.vol_offset));
        dt  = longint'(c.step_length);
        sdt = longint'(c.root_step_length);
        lx  = longint'(x);
        ly  = longint'(y);
        lz  = longint'(z);
        clipped = 1'b0;

        // local volatility
        bs    = fixed_mul(bet, lx, FRAC, clipped);
        inner = clip32(bs + s0, clipped);
        sig_r = fixed_mul(sig, inner, FRAC, clipped);

        // x update: drift plus diffusion
        kx = fixed_mul(kap, lx, FRAC, clipped);
        bx = clip32(ly - kx, clipped);
        dx = fixed_mul(bx, dt, FRAC, clipped);
        vs = fixed_mul(sig_r, sdt, FRAC, clipped);
        dz = fixed_mul(vs, lz, DRAW_FRAC, clipped);
        r.next_x = DATA_W'(clip32(lx + dx + dz, clipped));

        // y update: drift only
        sq = fixed_mul(sig_r, sig_r, FRAC, clipped);
        ky = fixed_mul(kap, ly, FRAC, clipped);
        by = clip32(sq - 2 * ky, clipped);
        dy = fixed_mul(by, dt, FRAC, clipped);
        r.next_y = DATA_W'(clip32(ly + dy, clipped));

        r.saturated = clipped;
        r.tag_out   = tag;
        return r;
    endfunction

    // predict on accepted requests, check accepted results in order
    always @(posedge clk)
    begin : scoreboard
        euler_out_t got;
        euler_out_t want;
        if (rst_n)
        begin
            if (step_ch.valid && !step_ch.ready)
                n_input_stalls++;
            if (step_ch.valid && step_ch.ready)
            begin
                predicted_steps.push_back(predict_euler_step(shadow_cfg, step_ch.factor_x,
                    step_ch.factor_y, step_ch.normal_draw, step_ch.path_tag));
                n_requests++;
            end
            if (result_ch.valid && result_ch.ready)
            begin
                got.next_x    = result_ch.next_x;
                got.next_y    = result_ch.next_y;
                got.saturated = result_ch.saturated;
                got.tag_out   = result_ch.tag_out;
                n_results++;
                if (got.saturated === 1'b1)
                    n_clipped++;
                if (predicted_steps.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS)
                        $display("%0t: result with nothing pending: x=%0d y=%0d sat=%0b tag=%h",
                                 $realtime, got.next_x, got.next_y, got.saturated, got.tag_out);
                end
                else
                begin
                    want = predicted_steps.pop_front();
                    if (got.next_x !== want.next_x || got.next_y !== want.next_y ||
                        got.saturated !== want.saturated || got.tag_out !== want.tag_out)
                    begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= MAX_REPORTS)
                        begin
                            $display("%0t: mismatch tag %h", $realtime, want.tag_out);
                            $display("    expected x=%0d y=%0d sat=%0b tag=%h",
                                     want.next_x, want.next_y, want.saturated, want.tag_out);
                            $display("    actual   x=%0d y=%0d sat=%0b tag=%h",
                                     got.next_x, got.next_y, got.saturated, got.tag_out);
                        end
                    end
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((step_ch.valid && step_ch.ready) || (result_ch.valid && result_ch.ready) ||
            (psel && penable) || !rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles, %0d results pending",
                     quiet_cycles, predicted_steps.size());
            $display("tb_quasi_gaussian_euler_step: FAIL");
            $finish;
        end
    end

    // result side: random stalls per result, plus a long hold-off on demand
    initial
    begin : result_side
        int n;
        result_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_len > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (hold_len) @(posedge clk);
                hold_len = 0;
            end
            n = (rx_gap_max > 0) ? $urandom_range(0, rx_gap_max) : 0;
            if (n > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(result_ch.valid && result_ch.ready) && hold_len == 0);
        end
    end

    // offer one request, after a random gap
    task automatic send_step(input logic signed [DATA_W-1:0] x,
                             input logic signed [DATA_W-1:0] y,
                             input logic signed [DRAW_W-1:0] z,
                             input logic [TAG_W-1:0] tag);
        int gap;
        gap = (tx_gap_max > 0) ? $urandom_range(0, tx_gap_max) : 0;
        if (gap > 0)
        begin
            step_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        step_ch.valid       <= 1'b1;
        step_ch.factor_x    <= x;
        step_ch.factor_y    <= y;
        step_ch.normal_draw <= z;
        step_ch.path_tag    <= tag;
        do
            @(posedge clk);
        while (!(step_ch.valid && step_ch.ready));
    endtask

    // stop offering and wait for every pending result
    task automatic drain_results();
        step_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (predicted_steps.size() != 0);
    endtask

    // apb setup and access phases
    task automatic apb_access(input logic wr, input logic [CFG_ADDR_W-1:0] addr,
                              input logic [CFG_DATA_W-1:0] wdata,
                              output logic [CFG_DATA_W-1:0] rdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        logic [CFG_DATA_W-1:0] rd;
        logic                  bad;
        apb_access(1'b0, CFG_ADDR_W'(int'(idx) * 4), '0, rd);
        if (idx == qge_pkg::REG_STEP_LENGTH || idx == qge_pkg::REG_ROOT_STEP_LENGTH)
            bad = (rd[DT_W-1:0] !== value[DT_W-1:0]);
        else
            bad = (rd !== value);
        if (bad)
        begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS)
                $display("%0t: register %s read back: expected %h actual %h",
                         $realtime, idx.name(), value, rd);
        end
    endtask

    task automatic set_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        logic [CFG_DATA_W-1:0] rd;
        apb_access(1'b1, CFG_ADDR_W'(int'(idx) * 4), value, rd);
        case (idx)
            qge_pkg::REG_MEAN_REVERSION:   shadow_cfg.mean_reversion   = value;
            qge_pkg::REG_VOL_SCALE:        shadow_cfg.vol_scale        = value;
            qge_pkg::REG_SKEW_SLOPE:       shadow_cfg.skew_slope       = value;
            qge_pkg::REG_VOL_OFFSET:       shadow_cfg.vol_offset       = value;
            qge_pkg::REG_STEP_LENGTH:      shadow_cfg.step_length      = value[DT_W-1:0];
            qge_pkg::REG_ROOT_STEP_LENGTH: shadow_cfg.root_step_length = value[DT_W-1:0];
            default: ;
        endcase
        check_reg(idx, value);
    endtask

    task automatic load_config(input qge_cfg_t c);
        set_reg(qge_pkg::REG_MEAN_REVERSION, c.mean_reversion);
        set_reg(qge_pkg::REG_VOL_SCALE, c.vol_scale);
        set_reg(qge_pkg::REG_SKEW_SLOPE, c.skew_slope);
        set_reg(qge_pkg::REG_VOL_OFFSET, c.vol_offset);
        set_reg(qge_pkg::REG_STEP_LENGTH, CFG_DATA_W'(c.step_length));
        set_reg(qge_pkg::REG_ROOT_STEP_LENGTH, CFG_DATA_W'(c.root_step_length));
        n_settings++;
    endtask

    function automatic int centered(input int half);
        return int'($urandom_range(0, 2 * half)) - half;
    endfunction

    // style 0: realistic market parameters, 1: wide, 2: any bit pattern
    function automatic qge_cfg_t draw_config(input int style);
        qge_cfg_t c;
        real      r;
        case (style)
            0:
            begin
                c.mean_reversion = $urandom_range(0, 1 << 23);
                c.vol_scale      = $urandom_range(0, 1 << 22);
                c.skew_slope     = centered(1 << 23);
                c.vol_offset     = $urandom_range(0, 1 << 22);
                c.step_length    = DT_W'($urandom_range(1, 1 << 24));
                r = $sqrt(real'(c.step_length) / 16777216.0) * 16777216.0;
                c.root_step_length = DT_W'(longint'(r));
            end
            1:
            begin
                c.mean_reversion   = centered(1 << 27);
                c.vol_scale        = centered(1 << 26);
                c.skew_slope       = centered(1 << 26);
                c.vol_offset       = centered(1 << 26);
                c.step_length      = DT_W'($urandom_range(0, 1 << 24));
                c.root_step_length = DT_W'($urandom_range(0, 1 << 24));
            end
            default:
            begin
                c.mean_reversion   = $urandom;
                c.vol_scale        = $urandom;
                c.skew_slope       = $urandom;
                c.vol_offset       = $urandom;
                c.step_length      = DT_W'($urandom);
                c.root_step_length = DT_W'($urandom);
            end
        endcase
        return c;
    endfunction

    // mostly realistic state, some wide, some any pattern
    function automatic logic signed [DATA_W-1:0] draw_state();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return centered(1 << 22);
        else if (roll < 90)
            return centered(1 << 28);
        return $urandom;
    endfunction

    task automatic send_random_step();
        logic signed [DRAW_W-1:0] z;
        if ($urandom_range(0, 99) < 85)
            z = DRAW_W'(centered(3 << DRAW_FRAC));
        else
            z = DRAW_W'($urandom);
        send_step(draw_state(), draw_state(), z, TAG_W'($urandom));
    endtask

    // registers come out of reset at zero, and a zero setting leaves x and y alone
    task automatic test_reset_values();
        check_reg(qge_pkg::REG_MEAN_REVERSION, '0);
        check_reg(qge_pkg::REG_VOL_SCALE, '0);
        check_reg(qge_pkg::REG_SKEW_SLOPE, '0);
        check_reg(qge_pkg::REG_VOL_OFFSET, '0);
        check_reg(qge_pkg::REG_STEP_LENGTH, '0);
        check_reg(qge_pkg::REG_ROOT_STEP_LENGTH, '0);
        send_step(Q_ONE, -Q_ONE, 16'sh1000, 16'h0001);
        send_step(Q_MAX, Q_MIN, 16'sh7fff, 16'hfffe);
        send_step(Q_MIN, Q_MAX, 16'sh8000, 16'h0000);
        drain_results();
    endtask

    // extremes of each field under a typical setting
    task automatic test_field_extremes();
        qge_cfg_t c;
        c.mean_reversion   = Q_ONE / 20;
        c.vol_scale        = Q_ONE / 100;
        c.skew_slope       = Q_ONE / 2;
        c.vol_offset       = Q_ONE / 100;
        c.step_length      = 25'h040_0000;
        c.root_step_length = 25'h080_0000;
        load_config(c);
        send_step(0, 0, 0, 16'h0000);
        send_step(Q_MAX, 0, 16'sh0800, 16'h0001);
        send_step(Q_MIN, 0, -16'sh0800, 16'h0002);
        send_step(0, Q_MAX, 0, 16'h0003);
        send_step(0, Q_MIN, 0, 16'h0004);
        send_step(Q_ONE, Q_ONE / 100, 16'sh7fff, 16'hffff);
        send_step(-Q_ONE, 0, 16'sh8000, 16'h8000);
        send_step(Q_MAX, Q_MAX, 16'sh7fff, 16'h7fff);
        send_step(Q_MIN, Q_MIN, 16'sh8000, 16'haaaa);
        send_step(1, -1, 1, 16'h5555);
        drain_results();
    endtask

    // clipping in every stage, step lengths above one
    task automatic test_stage_overflow();
        qge_cfg_t c;
        c.mean_reversion   = Q_MAX;
        c.vol_scale        = Q_MAX;
        c.skew_slope       = Q_MAX;
        c.vol_offset       = Q_MAX;
        c.step_length      = DT_MAX;
        c.root_step_length = DT_MAX;
        load_config(c);
        send_step(Q_ONE, Q_ONE, 16'sh1000, 16'h0101);
        send_step(Q_MIN, Q_MAX, -16'sh1000, 16'h0202);
        send_step(0, 0, 0, 16'h0303);
        drain_results();
        c.mean_reversion = Q_MIN;
        c.vol_scale      = Q_MIN;
        c.skew_slope     = Q_MIN;
        c.vol_offset     = Q_MIN;
        c.step_length    = '0;
        load_config(c);
        send_step(Q_MIN, Q_MIN, 16'sh8000, 16'h0404);
        send_step(Q_MAX, Q_MAX, 16'sh7fff, 16'h0505);
        send_step(-1, 1, -1, 16'h0606);
        drain_results();
    endtask

    // writes to unused register addresses change nothing
    task automatic test_unused_addresses();
        logic [CFG_DATA_W-1:0] rd;
        load_config(draw_config(0));
        apb_access(1'b1, CFG_ADDR_W'(NUM_REGS * 4), $urandom, rd);
        apb_access(1'b1, CFG_ADDR_W'((NUM_REGS + 1) * 4), $urandom, rd);
        check_reg(qge_pkg::REG_MEAN_REVERSION, shadow_cfg.mean_reversion);
        check_reg(qge_pkg::REG_VOL_SCALE, shadow_cfg.vol_scale);
        check_reg(qge_pkg::REG_SKEW_SLOPE, shadow_cfg.skew_slope);
        check_reg(qge_pkg::REG_VOL_OFFSET, shadow_cfg.vol_offset);
        check_reg(qge_pkg::REG_STEP_LENGTH, CFG_DATA_W'(shadow_cfg.step_length));
        check_reg(qge_pkg::REG_ROOT_STEP_LENGTH, CFG_DATA_W'(shadow_cfg.root_step_length));
        send_step(Q_ONE / 4, Q_ONE / 64, 16'sh0c00, 16'h0707);
        send_step(-Q_ONE / 4, Q_ONE / 32, -16'sh0c00, 16'h0808);
        drain_results();
    endtask

    // random settings, each with its own idling pattern
    task automatic test_random_phases();
        int p;
        int style;
        for (p = 0; p < PHASES; p++)
        begin
            case (p % 4)
                0: begin tx_gap_max = 0;       rx_gap_max = 0;       end
                1: begin tx_gap_max = MAX_GAP; rx_gap_max = MAX_GAP; end
                2: begin tx_gap_max = MAX_GAP; rx_gap_max = 0;       end
                default: begin tx_gap_max = 0; rx_gap_max = MAX_GAP; end
            endcase
            if (p % 2 == 0)
                style = 0;
            else if (p == 1 || p == 5)
                style = 1;
            else
                style = 2;
            load_config(draw_config(style));
            repeat (PHASE_ITEMS) send_random_step();
            drain_results();
        end
    endtask

    // output held off while requests keep coming, so the pipe fills
    task automatic test_output_hold();
        tx_gap_max = 0;
        rx_gap_max = 0;
        load_config(draw_config(0));
        hold_len = HOLD_CYCLES;
        repeat (48) send_random_step();
        drain_results();
    endtask

    initial
    begin
        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        step_ch.valid       = 1'b0;
        step_ch.factor_x    = '0;
        step_ch.factor_y    = '0;
        step_ch.normal_draw = '0;
        step_ch.path_tag    = '0;
        shadow_cfg          = '0;
        tx_gap_max          = MAX_GAP;
        rx_gap_max          = MAX_GAP;
        hold_len            = 0;
        mismatch_cnt        = 0;
        n_requests          = 0;
        n_results           = 0;
        n_clipped           = 0;
        n_settings          = 0;
        n_input_stalls      = 0;
        quiet_cycles        = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_field_extremes();
        test_stage_overflow();
        test_unused_addresses();
        test_random_phases();
        test_output_hold();

        // let any stray result show up
        drain_results();
        repeat (PIPE_LAT * 2) @(posedge clk);
        if (predicted_steps.size() != 0)
        begin
            mismatch_cnt += predicted_steps.size();
            $display("%0d expected results never arrived", predicted_steps.size());
        end

        $display("covered %0d requests and %0d results (%0d clipped) over %0d settings",
                 n_requests, n_results, n_clipped, n_settings);
        $display("input stalled %0d cycles; %0d failures", n_input_stalls, mismatch_cnt);
        if (mismatch_cnt == 0)
            $display("tb_quasi_gaussian_euler_step: PASS");
        else
            $display("tb_quasi_gaussian_euler_step: FAIL");
        $finish;
    end

endmodule
